// ----- sv/lkr_pkg.sv -----
package lkr_pkg;

  localparam int OP_W     = 2;
  localparam int FRAME_W  = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 4;
  localparam int DEPTH_W  = 4;
  localparam int CAP_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd2;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ACCESS        = 2'd0,
    OP_SET_EVICTABLE = 2'd1,
    OP_REMOVE        = 2'd2,
    OP_EVICT         = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_NOTHING       = 3'd1,
    ST_UNKNOWN       = 3'd2,
    ST_PINNED        = 3'd3,
    ST_OUT_OF_MEMORY = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UPDATE,
    S_CHECK,
    S_SCAN,
    S_PICK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic en;
    logic eligible;
  } scan_ctrl_t;

endpackage

// ----- sv/lkr_item_if.sv -----
interface lkr_item_if;
  logic                         valid;
  logic                         ready;
  logic [lkr_pkg::OP_W-1:0]     operation;
  logic [lkr_pkg::FRAME_W-1:0]  frame;
  logic                         evictable_flag;

  modport source (output valid, operation, frame, evictable_flag, input ready);
  modport sink (input valid, operation, frame, evictable_flag, output ready);
endinterface

// ----- sv/lkr_result_if.sv -----
interface lkr_result_if;
  logic                          valid;
  logic                          ready;
  logic [lkr_pkg::STATUS_W-1:0]  status;
  logic                          victim_valid;
  logic [lkr_pkg::FRAME_W-1:0]   victim_frame;
  logic [lkr_pkg::CAP_W-1:0]     evictable_count;

  modport source (output valid, status, victim_valid, victim_frame, evictable_count,
                  input ready);
  modport sink (input valid, status, victim_valid, victim_frame, evictable_count,
                output ready);
endinterface

// ----- sv/lkr_cfg_if.sv -----
interface lkr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lkr_pkg::CFG_IDX_W-1:0] index;
  logic [lkr_pkg::CAP_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/lkr_ram.sv -----
module lkr_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/lkr_scan.sv -----
module lkr_scan #(
  parameter int FRAME_IDS  = 64,
  parameter int STAMP_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lkr_pkg::scan_ctrl_t           ctrl,
  input  logic [$clog2(FRAME_IDS)-1:0]  idx,
  input  logic [lkr_pkg::COUNT_W-1:0]   count,
  input  logic [STAMP_BITS-1:0]         stamp,
  input  logic [STAMP_BITS-1:0]         counter,
  input  logic [lkr_pkg::DEPTH_W-1:0]   depth,
  output logic                          found,
  output logic [$clog2(FRAME_IDS)-1:0]  best_idx
);

  localparam int IDX_W = $clog2(FRAME_IDS);

  logic                  cold_found, warm_found;
  logic [IDX_W-1:0]      cold_idx, warm_idx;
  logic [STAMP_BITS-1:0] cold_age, warm_age;
  logic [STAMP_BITS-1:0] age, tier_age;
  logic                  warm, tier_found, take;

  // One subtract and one compare per entry; the tier picks which best is compared.
  always_comb begin
    age        = counter - stamp;
    warm       = (count >= depth);
    tier_found = warm ? warm_found : cold_found;
    tier_age   = warm ? warm_age : cold_age;
    take       = ctrl.en && ctrl.eligible && (!tier_found || (age > tier_age));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      cold_found <= 1'b0;
      warm_found <= 1'b0;
    end else if (take) begin
      if (warm) begin
        warm_found <= 1'b1;
      end else begin
        cold_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && warm) begin
      warm_idx <= idx;
      warm_age <= age;
    end
    if (take && !warm) begin
      cold_idx <= idx;
      cold_age <= age;
    end
  end

  assign found    = cold_found || warm_found;
  assign best_idx = cold_found ? cold_idx : warm_idx;

endmodule

// ----- sv/lru_k_frame_replacer_core.sv -----
// Two-tier LRU-K frame replacer. Each word on the item channel is one operation (record
// access, set evictable, remove or evict) on a frame, and each produces exactly one result
// word carrying a status, the evicted frame if any, and the number of evictable frames left.
// Frames with fewer than history_depth accesses form the cold tier; eviction takes the oldest
// evictable cold frame, else the oldest evictable warm frame, with ties going to the lowest
// frame number. Valid and evictable bits live in flip-flops and are cleared by reset; the
// access count and last stamp of every frame sit in one single-port-write RAM. The block
// works on one item at a time and is ready only when idle. A set evictable, a remove or
// an access to an unknown frame goes straight from execution to the done state; a record
// access to a new frame first passes the capacity check, and a repeat access rewrites its
// RAM word before that check. An evict, or a record access that leaves more frames tracked
// than capacity allows, also walks every entry through the RAM read port and the shared
// age comparator, one entry per cycle, then drains the read pipeline and picks the victim.
// The block is ready again in the cycle its result appears. A finished result waits in an
// output register; the next item is taken meanwhile, but its result is held back until the
// earlier word has been taken. Configuration writes are accepted at any time and must only
// be issued while the block is idle.
module lru_k_frame_replacer_core #(
  parameter int FRAME_IDS  = 64,
  parameter int STAMP_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  lkr_cfg_if.sink     cfg,
  lkr_item_if.sink    items,
  lkr_result_if.source results
);

  localparam int IDX_W  = $clog2(FRAME_IDS);
  localparam int CNT_W  = $clog2(FRAME_IDS + 1);
  localparam int WORD_W = lkr_pkg::COUNT_W + STAMP_BITS;

  // Configuration registers.
  logic [lkr_pkg::DEPTH_W-1:0] history_depth;
  logic [lkr_pkg::CAP_W-1:0]   capacity;

  // Control state.
  lkr_pkg::state_t state, state_next;
  logic [FRAME_IDS-1:0] valid_bits, valid_bits_next;
  logic [FRAME_IDS-1:0] evict_bits, evict_bits_next;
  logic [STAMP_BITS-1:0] stamp_counter, stamp_counter_next;
  logic [CNT_W-1:0] tracked, tracked_next;
  logic [CNT_W-1:0] evict_total, evict_total_next;
  logic [IDX_W:0] scan_issue, scan_issue_next;
  logic pipe_live, pipe_live_next;
  logic out_valid, out_valid_next;

  // Payload registers.
  lkr_pkg::op_t cur_op, cur_op_next;
  logic [IDX_W-1:0] cur_idx, cur_idx_next;
  logic cur_in_range, cur_in_range_next;
  logic cur_flag, cur_flag_next;
  logic [IDX_W-1:0] pipe_idx, pipe_idx_next;
  lkr_pkg::status_t res_status, res_status_next;
  logic res_vv, res_vv_next;
  logic [IDX_W-1:0] res_vidx, res_vidx_next;
  logic [lkr_pkg::STATUS_W-1:0] out_status, out_status_next;
  logic out_vv, out_vv_next;
  logic [lkr_pkg::FRAME_W-1:0] out_vframe, out_vframe_next;
  logic [lkr_pkg::CAP_W-1:0] out_count, out_count_next;

  // RAM ports.
  logic ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [lkr_pkg::COUNT_W-1:0] rd_count;

  // Scan unit.
  lkr_pkg::scan_ctrl_t scan_ctrl;
  logic scan_start;
  logic scan_found;
  logic [IDX_W-1:0] scan_best;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_depth <= lkr_pkg::DEPTH_RESET;
      capacity      <= lkr_pkg::CAPACITY_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == lkr_pkg::REG_HISTORY_DEPTH) begin
        history_depth <= cfg.data[lkr_pkg::DEPTH_W-1:0];
      end else if (cfg.index == lkr_pkg::REG_CAPACITY) begin
        capacity <= cfg.data;
      end
    end
  end

  assign items.ready = (state == lkr_pkg::S_IDLE);
  assign rd_count = ram_rdata[WORD_W-1 -: lkr_pkg::COUNT_W];

  lkr_ram #(
    .WIDTH(WORD_W),
    .DEPTH(FRAME_IDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The entry under evaluation is the one whose read was issued in the previous cycle.
  assign scan_ctrl.start    = scan_start;
  assign scan_ctrl.en       = pipe_live;
  assign scan_ctrl.eligible = valid_bits[pipe_idx] && evict_bits[pipe_idx];

  lkr_scan #(
    .FRAME_IDS (FRAME_IDS),
    .STAMP_BITS(STAMP_BITS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (scan_ctrl),
    .idx     (pipe_idx),
    .count   (rd_count),
    .stamp   (ram_rdata[STAMP_BITS-1:0]),
    .counter (stamp_counter),
    .depth   (history_depth),
    .found   (scan_found),
    .best_idx(scan_best)
  );

  always_comb begin
    state_next         = state;
    valid_bits_next    = valid_bits;
    evict_bits_next    = evict_bits;
    stamp_counter_next = stamp_counter;
    tracked_next       = tracked;
    evict_total_next   = evict_total;
    scan_issue_next    = scan_issue;
    pipe_live_next     = 1'b0;
    pipe_idx_next      = pipe_idx;
    cur_op_next        = cur_op;
    cur_idx_next       = cur_idx;
    cur_in_range_next  = cur_in_range;
    cur_flag_next      = cur_flag;
    res_status_next    = res_status;
    res_vv_next        = res_vv;
    res_vidx_next      = res_vidx;
    out_valid_next     = out_valid && !results.ready;
    out_status_next    = out_status;
    out_vv_next        = out_vv;
    out_vframe_next    = out_vframe;
    out_count_next     = out_count;
    ram_we             = 1'b0;
    ram_waddr          = cur_idx;
    ram_wdata          = {lkr_pkg::COUNT_W'(1), stamp_counter};
    ram_raddr          = cur_idx;
    scan_start         = 1'b0;

    unique case (state)
      lkr_pkg::S_IDLE: begin
        if (items.valid) begin
          cur_op_next       = lkr_pkg::op_t'(items.operation);
          cur_idx_next      = IDX_W'(items.frame);
          cur_in_range_next = (32'(items.frame) < 32'(FRAME_IDS));
          cur_flag_next     = items.evictable_flag;
          state_next        = lkr_pkg::S_EXEC;
        end
      end

      lkr_pkg::S_EXEC: begin
        res_status_next = lkr_pkg::ST_OK;
        res_vv_next     = 1'b0;
        res_vidx_next   = '0;
        state_next      = lkr_pkg::S_DONE;
        if (cur_op == lkr_pkg::OP_EVICT) begin
          scan_start      = 1'b1;
          scan_issue_next = '0;
          state_next      = lkr_pkg::S_SCAN;
        end else if (!cur_in_range) begin
          res_status_next = lkr_pkg::ST_UNKNOWN;
        end else begin
          unique case (cur_op)
            lkr_pkg::OP_ACCESS: begin
              if (!valid_bits[cur_idx]) begin
                // New frame: pinned, one access, stamped now.
                ram_we                   = 1'b1;
                valid_bits_next[cur_idx] = 1'b1;
                evict_bits_next[cur_idx] = 1'b0;
                tracked_next             = tracked + 1'b1;
                stamp_counter_next       = stamp_counter + 1'b1;
                state_next               = lkr_pkg::S_CHECK;
              end else begin
                state_next = lkr_pkg::S_UPDATE;
              end
            end
            lkr_pkg::OP_SET_EVICTABLE: begin
              if (!valid_bits[cur_idx]) begin
                res_status_next = lkr_pkg::ST_UNKNOWN;
              end else if (evict_bits[cur_idx] != cur_flag) begin
                evict_bits_next[cur_idx] = cur_flag;
                evict_total_next = cur_flag ? evict_total + 1'b1 : evict_total - 1'b1;
              end
            end
            lkr_pkg::OP_REMOVE: begin
              if (!valid_bits[cur_idx]) begin
                res_status_next = lkr_pkg::ST_UNKNOWN;
              end else if (!evict_bits[cur_idx]) begin
                res_status_next = lkr_pkg::ST_PINNED;
              end else begin
                valid_bits_next[cur_idx] = 1'b0;
                evict_bits_next[cur_idx] = 1'b0;
                tracked_next             = tracked - 1'b1;
                evict_total_next         = evict_total - 1'b1;
              end
            end
            lkr_pkg::OP_EVICT: begin
            end
          endcase
        end
      end

      lkr_pkg::S_UPDATE: begin
        // Repeat access: the count saturates, the stamp is renewed.
        ram_we             = 1'b1;
        ram_wdata          = {(rd_count == lkr_pkg::COUNT_MAX) ? rd_count : rd_count + 1'b1,
                              stamp_counter};
        stamp_counter_next = stamp_counter + 1'b1;
        state_next         = lkr_pkg::S_CHECK;
      end

      lkr_pkg::S_CHECK: begin
        if (32'(tracked) > 32'(capacity)) begin
          scan_start      = 1'b1;
          scan_issue_next = '0;
          state_next      = lkr_pkg::S_SCAN;
        end else begin
          state_next = lkr_pkg::S_DONE;
        end
      end

      lkr_pkg::S_SCAN: begin
        if (32'(scan_issue) < 32'(FRAME_IDS)) begin
          ram_raddr       = scan_issue[IDX_W-1:0];
          pipe_idx_next   = scan_issue[IDX_W-1:0];
          pipe_live_next  = 1'b1;
          scan_issue_next = scan_issue + 1'b1;
        end else if (!pipe_live) begin
          state_next = lkr_pkg::S_PICK;
        end
      end

      lkr_pkg::S_PICK: begin
        if (scan_found) begin
          valid_bits_next[scan_best] = 1'b0;
          evict_bits_next[scan_best] = 1'b0;
          tracked_next               = tracked - 1'b1;
          evict_total_next           = evict_total - 1'b1;
          res_vv_next                = 1'b1;
          res_vidx_next              = scan_best;
        end else if (cur_op == lkr_pkg::OP_EVICT) begin
          res_status_next = lkr_pkg::ST_NOTHING;
        end else begin
          res_status_next = lkr_pkg::ST_OUT_OF_MEMORY;
        end
        state_next = lkr_pkg::S_DONE;
      end

      lkr_pkg::S_DONE: begin
        if (!out_valid || results.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_vv_next     = res_vv;
          out_vframe_next = lkr_pkg::FRAME_W'(res_vidx);
          out_count_next  = lkr_pkg::CAP_W'(evict_total);
          state_next      = lkr_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = lkr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lkr_pkg::S_IDLE;
      valid_bits    <= '0;
      evict_bits    <= '0;
      stamp_counter <= '0;
      tracked       <= '0;
      evict_total   <= '0;
      scan_issue    <= '0;
      pipe_live     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      valid_bits    <= valid_bits_next;
      evict_bits    <= evict_bits_next;
      stamp_counter <= stamp_counter_next;
      tracked       <= tracked_next;
      evict_total   <= evict_total_next;
      scan_issue    <= scan_issue_next;
      pipe_live     <= pipe_live_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_op       <= cur_op_next;
    cur_idx      <= cur_idx_next;
    cur_in_range <= cur_in_range_next;
    cur_flag     <= cur_flag_next;
    pipe_idx     <= pipe_idx_next;
    res_status   <= res_status_next;
    res_vv       <= res_vv_next;
    res_vidx     <= res_vidx_next;
    out_status   <= out_status_next;
    out_vv       <= out_vv_next;
    out_vframe   <= out_vframe_next;
    out_count    <= out_count_next;
  end

  assign results.valid           = out_valid;
  assign results.status          = out_status;
  assign results.victim_valid    = out_vv;
  assign results.victim_frame    = out_vframe;
  assign results.evictable_count = out_count;

endmodule

// ----- sv/lkr_checker.sv -----
module lkr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lkr_pkg::STATUS_W-1:0] out_status,
  input logic                         out_victim_valid,
  input logic [lkr_pkg::FRAME_W-1:0]  out_victim_frame,
  input logic [lkr_pkg::CAP_W-1:0]    out_count
);

  // A stalled result word holds still.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_victim_valid) && $stable(out_victim_frame) && $stable(out_count))
    else $error("result word changed while stalled");

  // Once an item is taken the block works on it alone.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // A victim is only reported with an ok status.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_victim_valid |-> out_status == lkr_pkg::ST_OK)
    else $error("victim reported with an error status");

  // Without a victim the frame field reads zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_victim_valid |-> out_victim_frame == '0)
    else $error("victim frame set without a victim");

endmodule

bind lru_k_frame_replacer_core lkr_checker u_lkr_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (items.valid),
  .in_ready        (items.ready),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .out_status      (results.status),
  .out_victim_valid(results.victim_valid),
  .out_victim_frame(results.victim_frame),
  .out_count       (results.evictable_count)
);

// ----- tb/lkr_tb_if.sv -----
package lkr_tb_pkg;

  typedef struct packed {
    lkr_pkg::status_t                status;
    logic                            victim_valid;
    logic [lkr_pkg::FRAME_W-1:0]     victim_frame;
    logic [lkr_pkg::CAP_W-1:0]       evictable_count;
  } outcome_t;

  class replacer_scoreboard;
    logic [lkr_pkg::DEPTH_W-1:0] depth;
    logic [lkr_pkg::CAP_W-1:0]   cap;
    bit                          tracked [64];
    bit                          unpinned [64];
    logic [lkr_pkg::COUNT_W-1:0] hits [64];
    logic [31:0]                 stamp [64];
    logic [31:0]                 clock_now;
    int unsigned                 n_tracked;
    int unsigned                 n_evictable;
    outcome_t                    pending [$];
    int unsigned                 errors;

    function new();
      depth = lkr_pkg::DEPTH_RESET;
      cap = lkr_pkg::CAPACITY_RESET;
      clock_now = '0;
      n_tracked = 0;
      n_evictable = 0;
      errors = 0;
      foreach (tracked[i]) begin
        tracked[i] = 1'b0;
        unpinned[i] = 1'b0;
        hits[i] = '0;
        stamp[i] = '0;
      end
    endfunction

    function void write_reg(logic [lkr_pkg::CFG_IDX_W-1:0] idx, logic [lkr_pkg::CAP_W-1:0] val);
      if (idx == lkr_pkg::REG_HISTORY_DEPTH) depth = val[lkr_pkg::DEPTH_W-1:0];
      else if (idx == lkr_pkg::REG_CAPACITY) cap = val;
    endfunction

    function bit pick_victim(output int unsigned victim);
      bit found;
      logic [31:0] best_age, age;
      bit warm;
      victim = 0;
      for (int tier = 0; tier < 2; tier++) begin
        found = 1'b0;
        best_age = '0;
        for (int f = 0; f < 64; f++) begin
          if (tracked[f] && unpinned[f]) begin
            warm = hits[f] >= depth;
            age = clock_now - stamp[f];
            if (warm == (tier == 1) && (!found || age > best_age)) begin
              found = 1'b1;
              victim = unsigned'(f);
              best_age = age;
            end
          end
        end
        if (found) begin
          tracked[victim] = 1'b0;
          unpinned[victim] = 1'b0;
          n_tracked--;
          n_evictable--;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Works out the result of one accepted operation and queues it.
    function void note_item(lkr_pkg::op_t op, logic [lkr_pkg::FRAME_W-1:0] frame, logic flag);
      outcome_t o;
      int unsigned v;
      o = '0;
      o.status = lkr_pkg::ST_OK;
      case (op)
        lkr_pkg::OP_EVICT: begin
          if (pick_victim(v)) begin
            o.victim_valid = 1'b1;
            o.victim_frame = lkr_pkg::FRAME_W'(v);
          end else o.status = lkr_pkg::ST_NOTHING;
        end
        lkr_pkg::OP_ACCESS: begin
          if (!tracked[frame]) begin
            tracked[frame] = 1'b1;
            unpinned[frame] = 1'b0;
            hits[frame] = lkr_pkg::COUNT_W'(1);
            n_tracked++;
          end else if (hits[frame] < lkr_pkg::COUNT_MAX) hits[frame]++;
          stamp[frame] = clock_now;
          clock_now++;
          if (n_tracked > cap) begin
            if (pick_victim(v)) begin
              o.victim_valid = 1'b1;
              o.victim_frame = lkr_pkg::FRAME_W'(v);
            end else o.status = lkr_pkg::ST_OUT_OF_MEMORY;
          end
        end
        lkr_pkg::OP_SET_EVICTABLE: begin
          if (!tracked[frame]) o.status = lkr_pkg::ST_UNKNOWN;
          else if (unpinned[frame] != flag) begin
            unpinned[frame] = flag;
            if (flag) n_evictable++;
            else n_evictable--;
          end
        end
        default: begin
          if (!tracked[frame]) o.status = lkr_pkg::ST_UNKNOWN;
          else if (!unpinned[frame]) o.status = lkr_pkg::ST_PINNED;
          else begin
            tracked[frame] = 1'b0;
            unpinned[frame] = 1'b0;
            n_tracked--;
            n_evictable--;
          end
        end
      endcase
      o.evictable_count = lkr_pkg::CAP_W'(n_evictable);
      pending.insert(pending.size(), o);
    endfunction

    task report(string line);
      $display("mismatch: %s", line);
      errors++;
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status)
        report($sformatf("status got %0d expected %0d", got.status, want.status));
      if (got.victim_valid != want.victim_valid)
        report($sformatf("victim_valid got %0d expected %0d", got.victim_valid,
                         want.victim_valid));
      if (got.victim_frame != want.victim_frame)
        report($sformatf("victim_frame got %0d expected %0d", got.victim_frame,
                         want.victim_frame));
      if (got.evictable_count != want.evictable_count)
        report($sformatf("evictable_count got %0d expected %0d", got.evictable_count,
                         want.evictable_count));
    endtask
  endclass
endpackage

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int SCAN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lkr_cfg_if    cfg ();
  lkr_item_if   items ();
  lkr_result_if results ();

  lru_k_frame_replacer_core dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg.sink),
    .items   (items.sink),
    .results (results.source)
  );

  lkr_tb_pkg::replacer_scoreboard board = new();

  // The receiver is ready or stalls at random, and may be told to hold off for a while.
  bit hold_off = 1'b0;
  bit busy_sink = 1'b0;
  int idle_run = 0;
  bit done = 1'b0;
  int gap_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    items.valid = 1'b0;
    items.operation = '0;
    items.frame = '0;
    items.evictable_flag = 1'b0;
    results.ready = 1'b0;
  end

  // Scoreboard updates happen on the clock edge where the handshake is seen, so the
  // expected word is always queued before its result can possibly appear.
  always @(posedge clk) begin
    lkr_tb_pkg::outcome_t got;
    if (!rst) begin
      if (items.valid && items.ready)
        board.note_item(lkr_pkg::op_t'(items.operation), items.frame, items.evictable_flag);
      if (results.valid && results.ready) begin
        got.status = lkr_pkg::status_t'(results.status);
        got.victim_valid = results.victim_valid;
        got.victim_frame = results.victim_frame;
        got.evictable_count = results.evictable_count;
        board.check_result(got);
      end
      if (cfg.valid && cfg.ready) board.write_reg(cfg.index, cfg.data);
    end
  end

  // Receiver stall pattern: stretches of readiness, short random stalls, and the long
  // hold-off when asked for.
  always @(posedge clk) begin
    if (rst || hold_off) results.ready <= 1'b0;
    else if (busy_sink) results.ready <= ($urandom_range(0, 3) != 0);
    else results.ready <= 1'b1;
  end

  initial begin
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      busy_sink = ~busy_sink;
    end
  end

  // Watchdog: ends the run if nothing has been accepted for too long.
  always @(posedge clk) begin
    if (items.valid && items.ready || results.valid && results.ready || cfg.valid && cfg.ready
        || rst || hold_off || done)
      idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run > STALL_LIMIT) begin
      $display("FAIL lru_k_frame_replacer_core");
      $finish;
    end
  end

  // Sends one operation word. Words go out in bursts of random length with random gaps
  // in between; valid stays high after acceptance when the next word follows at once.
  task automatic send_word(lkr_pkg::op_t op, logic [lkr_pkg::FRAME_W-1:0] frame, logic flag);
    if (gap_left == 0) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap_left = $urandom_range(1, 20);
    end
    gap_left--;
    items.valid <= 1'b1;
    items.operation <= op;
    items.frame <= frame;
    items.evictable_flag <= flag;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
  endtask

  task automatic drain();
    items.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [lkr_pkg::CFG_IDX_W-1:0] idx, logic [lkr_pkg::CAP_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // A random operation, biased toward a small pool of frames so that entries are reused,
  // pinned and unpinned often enough to make evictions meaningful.
  task automatic random_word(int pool);
    lkr_pkg::op_t op;
    logic [lkr_pkg::FRAME_W-1:0] f;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) op = lkr_pkg::OP_ACCESS;
    else if (r < 75) op = lkr_pkg::OP_SET_EVICTABLE;
    else if (r < 88) op = lkr_pkg::OP_REMOVE;
    else op = lkr_pkg::OP_EVICT;
    f = ($urandom_range(0, 9) == 0) ? lkr_pkg::FRAME_W'($urandom_range(0, 63))
                                    : lkr_pkg::FRAME_W'($urandom_range(0, pool - 1));
    send_word(op, f, $urandom_range(0, 3) != 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings: empty evict, unknown frames, a new frame,
    // repeat access to saturation, pinning and removal.
    send_word(lkr_pkg::OP_EVICT, 6'd0, 1'b0);
    send_word(lkr_pkg::OP_SET_EVICTABLE, 6'd63, 1'b1);
    send_word(lkr_pkg::OP_REMOVE, 6'd5, 1'b0);
    send_word(lkr_pkg::OP_ACCESS, 6'd63, 1'b0);
    send_word(lkr_pkg::OP_REMOVE, 6'd63, 1'b0);
    for (int i = 0; i < 16; i++) send_word(lkr_pkg::OP_ACCESS, 6'd0, 1'b0);
    send_word(lkr_pkg::OP_SET_EVICTABLE, 6'd0, 1'b1);
    send_word(lkr_pkg::OP_SET_EVICTABLE, 6'd63, 1'b1);
    send_word(lkr_pkg::OP_EVICT, 6'd63, 1'b1);
    send_word(lkr_pkg::OP_REMOVE, 6'd0, 1'b0);
    drain();

    // Random phases through several settings, extremes included.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          write_reg(lkr_pkg::REG_HISTORY_DEPTH, 7'd0);
          write_reg(lkr_pkg::REG_CAPACITY, 7'd1);
        end
        1: begin
          write_reg(lkr_pkg::REG_HISTORY_DEPTH, 7'd15);
          write_reg(lkr_pkg::REG_CAPACITY, 7'd64);
        end
        2: begin
          write_reg(lkr_pkg::REG_HISTORY_DEPTH, 7'd1);
          write_reg(lkr_pkg::REG_CAPACITY, 7'd4);
        end
        3: begin
          write_reg(lkr_pkg::REG_HISTORY_DEPTH, 7'd3);
          write_reg(lkr_pkg::REG_CAPACITY, 7'd0);
        end
        4: begin
          write_reg(lkr_pkg::REG_HISTORY_DEPTH, 7'd2);
          write_reg(lkr_pkg::REG_CAPACITY, 7'd127);
        end
        5: begin
          write_reg(lkr_pkg::REG_HISTORY_DEPTH, lkr_pkg::CAP_W'($urandom_range(0, 15)));
          write_reg(lkr_pkg::REG_CAPACITY, lkr_pkg::CAP_W'($urandom_range(1, 16)));
        end
        default: begin
          write_reg(lkr_pkg::REG_HISTORY_DEPTH, 7'd2);
          write_reg(lkr_pkg::REG_CAPACITY, 7'd8);
        end
      endcase
      for (int n = 0; n < 250; n++) begin
        // Long receiver hold-off once, with the sender still offering items.
        if (phase == 2 && n == 20) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (600) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        // Sender pause until everything outstanding has returned.
        if (n == 125) begin
          items.valid <= 1'b0;
          @(posedge clk);
          while (board.pending.size() != 0) @(posedge clk);
        end
        random_word((phase == 1) ? 64 : 12);
      end
      drain();
    end

    done = 1'b1;
    if (board.errors == 0) $display("PASS lru_k_frame_replacer_core");
    else $display("FAIL lru_k_frame_replacer_core");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lkr_pkg.sv
sv/lkr_item_if.sv
sv/lkr_result_if.sv
sv/lkr_cfg_if.sv
sv/lkr_ram.sv
sv/lkr_scan.sv
sv/lru_k_frame_replacer_core.sv
sv/lkr_checker.sv
tb/lkr_tb_if.sv
tb/tb.sv
